[src/pulse_width_frame_transmitter_top_assert.svh]
// Assertion macros for the pulse-width frame transmitter.
// Used by the modules that check their own logic; needs no package.
`ifndef PULSE_WIDTH_FRAME_TRANSMITTER_TOP_ASSERT_SVH
`define PULSE_WIDTH_FRAME_TRANSMITTER_TOP_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define PWFT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define PWFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pwft_pkg.sv]
// Shared types and constants for the pulse-width frame transmitter.
// No dependencies.
package pwft_pkg;

  localparam int unsigned LenW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_START_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ONE_LENGTH = 2'd2;

  localparam logic [LenW-1:0] START_LENGTH_RST = 8'd20;
  localparam logic [LenW-1:0] ZERO_LENGTH_RST = 8'd5;
  localparam logic [LenW-1:0] ONE_LENGTH_RST = 8'd10;
  localparam logic [LenW-1:0] HOLD_RST = 8'd1;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_START_HIGH = 7'b0000010,
    PH_START_LOW  = 7'b0000100,
    PH_BIT_HIGH   = 7'b0001000,
    PH_BIT_LOW    = 7'b0010000,
    PH_STOP_HIGH  = 7'b0100000,
    PH_STOP_LOW   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic bit_value;
    logic bit_available;
    logic message_waiting;
  } in_item_t;

  typedef struct packed {
    logic message_taken;
    logic bit_taken;
    logic line_level;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_stage_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } out_stage_t;

endpackage

[src/pwft_in_reg.sv]
// Input register stage of the pulse-width frame transmitter.
// Depends on pwft_pkg.
module pwft_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pwft_pkg::in_item_t  in_item,
  output pwft_pkg::in_stage_t stage,
  input  logic                stage_ready
);

  logic               vld_r;
  logic               vld_nxt;
  pwft_pkg::in_item_t item_r;

  assign in_tready = !vld_r || stage_ready;
  assign vld_nxt   = in_tready ? in_tvalid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = vld_r;
  assign stage.item  = item_r;

endmodule

[src/pwft_step.sv]
// Framing state machine, hold counter and length registers.
// Depends on pwft_pkg and pulse_width_frame_transmitter_top_assert.svh.
`include "pulse_width_frame_transmitter_top_assert.svh"

module pwft_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [pwft_pkg::CfgIdxW-1:0]          cfg_addr,
  input  logic [pwft_pkg::LenW-1:0]             cfg_wdata,
  input  pwft_pkg::in_stage_t                   stage_in,
  output logic                                 stage_ready,
  output pwft_pkg::out_stage_t                  stage_out,
  input  logic                                 out_ready
);

  logic [pwft_pkg::LenW-1:0] start_len_r;
  logic [pwft_pkg::LenW-1:0] zero_len_r;
  logic [pwft_pkg::LenW-1:0] one_len_r;

  pwft_pkg::phase_t          phase_r;
  pwft_pkg::phase_t          phase_nxt;
  logic [pwft_pkg::LenW-1:0] hold_r;
  logic [pwft_pkg::LenW-1:0] hold_nxt;
  logic                      line_r;
  logic                      line_nxt;
  logic                      took_bit;
  logic                      took_msg;
  logic                      fire;
  logic                      run_out;

  assign stage_ready = out_ready;
  assign fire        = stage_in.valid && out_ready;
  assign run_out     = (hold_r <= pwft_pkg::HOLD_RST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_len_r <= pwft_pkg::START_LENGTH_RST;
      zero_len_r  <= pwft_pkg::ZERO_LENGTH_RST;
      one_len_r   <= pwft_pkg::ONE_LENGTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        pwft_pkg::CFG_START_LENGTH: start_len_r <= cfg_wdata;
        pwft_pkg::CFG_ZERO_LENGTH:  zero_len_r  <= cfg_wdata;
        pwft_pkg::CFG_ONE_LENGTH:   one_len_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    line_nxt  = line_r;
    took_bit  = 1'b0;
    took_msg  = 1'b0;
    if (!run_out) begin
      hold_nxt = hold_r - 8'd1;
    end else begin
      case (phase_r)
        pwft_pkg::PH_START_HIGH: begin
          line_nxt  = 1'b1;
          hold_nxt  = start_len_r;
          phase_nxt = pwft_pkg::PH_START_LOW;
        end
        pwft_pkg::PH_START_LOW: begin
          line_nxt  = 1'b0;
          hold_nxt  = start_len_r;
          phase_nxt = pwft_pkg::PH_BIT_HIGH;
        end
        pwft_pkg::PH_BIT_HIGH: begin
          if (stage_in.item.bit_available) begin
            line_nxt  = 1'b1;
            hold_nxt  = stage_in.item.bit_value ? one_len_r : zero_len_r;
            phase_nxt = pwft_pkg::PH_BIT_LOW;
            took_bit  = 1'b1;
          end else begin
            line_nxt  = 1'b0;
            phase_nxt = pwft_pkg::PH_STOP_HIGH;
          end
        end
        pwft_pkg::PH_BIT_LOW: begin
          line_nxt  = 1'b0;
          phase_nxt = pwft_pkg::PH_BIT_HIGH;
        end
        pwft_pkg::PH_STOP_HIGH: begin
          line_nxt  = 1'b1;
          hold_nxt  = start_len_r;
          phase_nxt = pwft_pkg::PH_STOP_LOW;
        end
        pwft_pkg::PH_STOP_LOW: begin
          line_nxt  = 1'b0;
          hold_nxt  = start_len_r;
          phase_nxt = pwft_pkg::PH_IDLE;
        end
        default: begin
          if (stage_in.item.message_waiting) begin
            phase_nxt = pwft_pkg::PH_START_HIGH;
            took_msg  = 1'b1;
          end else begin
            phase_nxt = pwft_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pwft_pkg::PH_IDLE;
      hold_r  <= pwft_pkg::HOLD_RST;
      line_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      line_r  <= line_nxt;
    end
  end

  assign stage_out.valid              = fire;
  assign stage_out.item.line_level    = line_nxt;
  assign stage_out.item.bit_taken     = took_bit;
  assign stage_out.item.message_taken = took_msg;

  `PWFT_ASSERT_SAME(a_msg_only_idle, clk, rst_n, fire && took_msg,
    phase_r == pwft_pkg::PH_IDLE && run_out, "message taken outside idle")
  `PWFT_ASSERT_SAME(a_bit_only_high, clk, rst_n, fire && took_bit,
    phase_r == pwft_pkg::PH_BIT_HIGH && run_out, "bit taken outside bit-high phase")
  `PWFT_ASSERT_NEXT(a_hold_freezes, clk, rst_n, fire && !run_out,
    phase_r == $past(phase_r) && line_r == $past(line_r) && hold_r == $past(hold_r) - 8'd1,
    "hold countdown changed phase or line")
  `PWFT_ASSERT_NEXT(a_idle_stall, clk, rst_n, !fire,
    phase_r == $past(phase_r) && hold_r == $past(hold_r), "state moved without a word")

endmodule

[src/pwft_out_reg.sv]
// Result register stage of the pulse-width frame transmitter.
// Depends on pwft_pkg.
module pwft_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pwft_pkg::out_stage_t stage,
  output logic                 stage_ready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output pwft_pkg::out_item_t  out_item
);

  logic                vld_r;
  logic                vld_nxt;
  pwft_pkg::out_item_t item_r;

  assign stage_ready = !vld_r || out_tready;
  assign vld_nxt     = stage_ready ? stage.valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready) begin
      item_r <= stage.item;
    end
  end

  assign out_tvalid = vld_r;
  assign out_item   = item_r;

endmodule

[src/pulse_width_frame_transmitter_top.sv]
// Pulse-width frame transmitter: input register, framing step, result register.
// A word goes from the input register via the framing step to the result register.
// Throughput: one word per cycle unless out_tready stalls; input register and result
// register both load whenever the stage ahead is empty or handing off.
// Reset (rst_n low, synchronous): idle phase, hold one, line low, length
// registers at 20/5/10, both stages empty.
module pulse_width_frame_transmitter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] message_waiting, [1] bit_available, [2] bit_value
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] line_level, [1] bit_taken, [2] message_taken
);

  pwft_pkg::in_item_t   in_item;
  pwft_pkg::in_stage_t  in_stage;
  pwft_pkg::out_stage_t res_stage;
  pwft_pkg::out_item_t  out_item;
  logic                 step_ready;
  logic                 out_ready;

  assign in_item.message_waiting = in_tdata[0];
  assign in_item.bit_available   = in_tdata[1];
  assign in_item.bit_value       = in_tdata[2];

  pwft_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_item     (in_item),
    .stage       (in_stage),
    .stage_ready (step_ready)
  );

  pwft_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .stage_in    (in_stage),
    .stage_ready (step_ready),
    .stage_out   (res_stage),
    .out_ready   (out_ready)
  );

  pwft_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (res_stage),
    .stage_ready (out_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_item    (out_item)
  );

  assign out_tdata = {5'b00000, out_item.message_taken, out_item.bit_taken,
                      out_item.line_level};

endmodule
